// ===== sv/rde_pkg.sv =====
// ============================================================================
// rde_pkg
// Shared constants and controller/datapath handshake types of the radix
// digit emitter.
// ============================================================================
package rde_pkg;

    // Default sizing of the top level
    localparam int VALUE_BITS_DEF = 31;
    localparam int MAX_DIGITS_DEF = 31;

    // Radix register
    localparam int          RADIX_W     = 8;
    localparam logic [7:0]  RADIX_RESET = 8'd10;
    localparam logic [7:0]  RADIX_MIN   = 8'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // take a new value, clear the digit count
        logic div_init;   // clear remainder and bit counter
        logic div_step;   // one restoring division bit
        logic push;       // store remainder, count up
        logic rd_init;    // point readout at the top of the stack
        logic rd;         // read the stack entry under the pointer
        logic ptr_dec;    // move readout pointer down one entry
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic q_zero;     // quotient is zero
        logic cnt_full;   // stack holds the maximum number of digits
        logic cnt_zero;   // stack is empty
        logic bit_last;   // final division bit in progress
        logic ptr_zero;   // readout pointer at the least significant digit
    } t_stat;

endpackage

// ===== sv/rde_datapath.sv =====
// ============================================================================
// rde_datapath
// Radix register, bit-serial restoring divider, digit stack and readout
// register of the radix digit emitter.
// ============================================================================
module rde_datapath #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rde_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rde_pkg::RADIX_W-1:0] i_cfg_data,
    input  logic [VALUE_BITS-1:0]       i_value,
    input  rde_pkg::t_cmd               i_cmd,
    output rde_pkg::t_stat              o_stat,
    output logic [rde_pkg::RADIX_W-1:0] o_digit
);
    import rde_pkg::*;

    localparam int BIT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int PTR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic [RADIX_W-1:0]    r_radix;
    logic [RADIX_W-1:0]    r_div;
    logic [VALUE_BITS-1:0] r_q;
    logic [RADIX_W-1:0]    r_rem;
    logic [BIT_W-1:0]      r_bit;
    logic [CNT_W-1:0]      r_cnt;
    logic [PTR_W-1:0]      r_ptr;
    logic [RADIX_W-1:0]    r_rd_data;
    logic [RADIX_W-1:0]    r_stack [MAX_DIGITS];

    logic [RADIX_W:0]      rem_sh;
    logic                  ge;
    logic [RADIX_W:0]      rem_sub;
    logic [RADIX_W-1:0]    n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh  = {r_rem, r_q[VALUE_BITS-1]};
        ge      = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
        n_rem   = ge ? rem_sub[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
            r_cnt   <= '0;
            r_q     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_radix <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_q   <= i_value;
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_q <= {r_q[VALUE_BITS-2:0], ge};
            end
            if (i_cmd.push) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div <= (r_radix < RADIX_MIN) ? RADIX_MIN : r_radix;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_bit <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_bit <= r_bit + BIT_W'(1);
        end
        if (i_cmd.rd_init) begin
            r_ptr <= PTR_W'(r_cnt - CNT_W'(1));
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= r_ptr - PTR_W'(1);
        end
    end

    // Digit stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[PTR_W'(r_cnt)] <= r_rem;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_stack[r_ptr];
        end
    end

    assign o_stat.q_zero   = (r_q == '0);
    assign o_stat.cnt_full = (r_cnt == CNT_W'(MAX_DIGITS));
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.bit_last = (r_bit == BIT_W'(VALUE_BITS - 1));
    assign o_stat.ptr_zero = (r_ptr == '0);
    assign o_digit         = r_rd_data;

    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_rem < r_div))
        else $error("remainder not below radix at push");

    a_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond stack depth");

endmodule

// ===== sv/rde_ctrl.sv =====
// ============================================================================
// rde_ctrl
// Sequencer of the radix digit emitter: load, divide digit by digit, then
// pop the stack onto the output channel.
// ============================================================================
module rde_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rde_pkg::t_stat i_stat,
    output rde_pkg::t_cmd  o_cmd
);
    import rde_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIV   = 6'b000100,
        S_PUSH  = 6'b001000,
        S_READ  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.q_zero || i_stat.cnt_full) begin
                    if (i_stat.cnt_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_init = 1'b1;
                        n_state       = S_READ;
                    end
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.bit_last) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_CHECK;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.ptr_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.ptr_dec = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/radix_digit_emitter_unit.sv =====
// ============================================================================
// radix_digit_emitter_unit
// Converts one unsigned integer into its digits in a programmable radix and
// streams them out most significant first, tlast on the final digit.
// ============================================================================
//
//  channel   | direction | payload                          | accept
//  ----------+-----------+----------------------------------+----------------------
//  s_axis    | in        | tdata: value                     | s_axis_tvalid & tready
//  m_axis    | out       | tdata: digit, tlast: last_digit  | m_axis_tvalid & tready
//  cfg       | in        | i_cfg_data: radix                | i_cfg_valid & o_cfg_ready
//
//  Sequence: one accept, then per digit one check, VALUE_BITS restoring
//  divider steps and one push, one final check, and per emitted digit a
//  stack read, then output. A zero value emits nothing.
//  One item is in flight at a time; s_axis_tready is high only when idle.
//  A stalled m_axis holds the current digit and the whole sequencer.
//  Reset (synchronous, active low) returns to idle and sets the radix to 10;
//  the digit stack needs no clearing, only digits of the current item are read.
//  Radix values of 0 and 1 are treated as 2.
//
module radix_digit_emitter_unit #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rde_pkg::MAX_DIGITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input items
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // [VALUE_BITS-1:0] value
    // Result items
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rde_pkg::RADIX_W-1:0]          m_axis_tdata,  // [7:0] digit
    output logic                                 m_axis_tlast,  // last_digit
    // Radix register write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rde_pkg::RADIX_W-1:0]          i_cfg_data     // [7:0] radix
);
    import rde_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Register writes are always taken; the user must send them only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    rde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rde_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_value    (s_axis_tdata[VALUE_BITS-1:0]),  // drop padding bits
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_digit    (m_axis_tdata)
    );

    // Final digit is the bottom of the stack
    assign m_axis_tlast = m_axis_tvalid & stat.ptr_zero;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a digit is pending");

    a_no_digit_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("digit shown before conversion began");

endmodule
